[hdl/jsu_pkg.sv]
// Shared types, constants, and decode and UTF-8 encode functions for the JSON string unescaper.
package jsu_pkg;

  // Decoder phase.
  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_STR  = 4'd1,
    PH_ESC  = 4'd2,
    PH_HEX1 = 4'd3,
    PH_BS2  = 4'd4,
    PH_U2   = 4'd5,
    PH_HEX2 = 4'd6
  } phase_t;

  // Result kind codes.
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // Character codes.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_U     = 8'h75;

  // Surrogate ranges and code point offset.
  localparam logic [15:0] HI_SUR_LO = 16'hd800;
  localparam logic [15:0] HI_SUR_HI = 16'hdbff;
  localparam logic [15:0] LO_SUR_LO = 16'hdc00;
  localparam logic [15:0] LO_SUR_HI = 16'hdfff;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // Up to four result bytes, with a count of 0 to 4 and a shared kind.
  typedef struct packed {
    logic [2:0]      cnt;
    kind_t           kind;
    logic [3:0][7:0] bytes;
  } res_t;

  // Hex digit: bit 4 set when the character is a valid digit.
  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'd0;
    if (ch >= 8'h30 && ch <= 8'h39) r = {1'b1, ch[3:0]};
    else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46))
      r = {1'b1, ch[3:0] + 4'd9};
    return r;
  endfunction

  // Single-letter escape: bit 8 set when the letter is known.
  function automatic logic [8:0] escape_letter(input logic [7:0] ch);
    logic [8:0] r;
    case (ch)
      CH_QUOTE: r = {1'b1, CH_QUOTE};
      CH_BSL:   r = {1'b1, CH_BSL};
      CH_SLASH: r = {1'b1, CH_SLASH};
      8'h62:    r = {1'b1, CH_BS};
      8'h66:    r = {1'b1, CH_FF};
      8'h6e:    r = {1'b1, CH_LF};
      8'h72:    r = {1'b1, CH_CR};
      8'h74:    r = {1'b1, CH_TAB};
      default:  r = 9'd0;
    endcase
    return r;
  endfunction

  // UTF-8 encoding of a code point into one to four data bytes.
  function automatic res_t utf8_encode(input logic [20:0] cp);
    res_t r;
    r.kind  = KIND_DATA;
    r.bytes = '0;
    if (cp < 21'h80) begin
      r.cnt      = 3'd1;
      r.bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      r.cnt      = 3'd2;
      r.bytes[0] = 8'hc0 | {3'b0, cp[10:6]};
      r.bytes[1] = 8'h80 | {2'b0, cp[5:0]};
    end else if (cp < 21'h10000) begin
      r.cnt      = 3'd3;
      r.bytes[0] = 8'he0 | {4'b0, cp[15:12]};
      r.bytes[1] = 8'h80 | {2'b0, cp[11:6]};
      r.bytes[2] = 8'h80 | {2'b0, cp[5:0]};
    end else begin
      r.cnt      = 3'd4;
      r.bytes[0] = 8'hf0 | {5'b0, cp[20:18]};
      r.bytes[1] = 8'h80 | {2'b0, cp[17:12]};
      r.bytes[2] = 8'h80 | {2'b0, cp[11:6]};
      r.bytes[3] = 8'h80 | {2'b0, cp[5:0]};
    end
    return r;
  endfunction

endpackage

[hdl/jsu_decoder.sv]
// Escape decoder: phase and hex state, and the results of the current byte.
module jsu_decoder (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          end_of_input,
  output jsu_pkg::res_t res
);
  import jsu_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] hex_accum, hex_accum_next;
  logic [1:0]  digit_count, digit_count_next;
  logic [9:0]  high_surrogate, high_surrogate_next;

  logic [4:0]  hex_d;
  logic [8:0]  esc;
  logic [15:0] acc_v;
  logic [20:0] supp_cp;
  res_t        err_res;

  assign hex_d   = hex_value(in_byte);
  assign esc     = escape_letter(in_byte);
  assign acc_v   = {hex_accum[11:0], hex_d[3:0]};
  assign supp_cp = SUPP_BASE + {1'b0, high_surrogate, acc_v[9:0]};

  always_comb begin
    err_res       = '0;
    err_res.cnt   = 3'd1;
    err_res.kind  = KIND_ERROR;
  end

  // Next state and results for the byte on the input.
  always_comb begin
    phase_next          = phase;
    hex_accum_next      = hex_accum;
    digit_count_next    = digit_count;
    high_surrogate_next = high_surrogate;
    res                 = '0;
    res.kind            = KIND_DATA;
    if (end_of_input) begin
      phase_next          = PH_IDLE;
      hex_accum_next      = '0;
      digit_count_next    = '0;
      high_surrogate_next = '0;
      res                 = err_res;
    end else begin
      case (phase)
        PH_IDLE: begin
          if (in_byte == CH_QUOTE) begin
            phase_next = PH_STR;
          end else if (!(in_byte inside {CH_SPACE, CH_TAB, CH_LF, CH_CR})) begin
            res = err_res;
          end
        end
        PH_STR: begin
          if (in_byte == CH_QUOTE) begin
            phase_next = PH_IDLE;
            res.cnt    = 3'd1;
            res.kind   = KIND_DONE;
          end else if (in_byte == CH_BSL) begin
            phase_next = PH_ESC;
          end else begin
            res.cnt      = 3'd1;
            res.bytes[0] = in_byte;
          end
        end
        PH_ESC: begin
          if (in_byte == CH_U) begin
            phase_next       = PH_HEX1;
            hex_accum_next   = '0;
            digit_count_next = '0;
          end else if (esc[8]) begin
            phase_next   = PH_STR;
            res.cnt      = 3'd1;
            res.bytes[0] = esc[7:0];
          end else begin
            phase_next = PH_IDLE;
            res        = err_res;
          end
        end
        PH_BS2: begin
          if (in_byte == CH_BSL) begin
            phase_next = PH_U2;
          end else begin
            phase_next          = PH_IDLE;
            high_surrogate_next = '0;
            res                 = err_res;
          end
        end
        PH_U2: begin
          if (in_byte == CH_U) begin
            phase_next       = PH_HEX2;
            hex_accum_next   = '0;
            digit_count_next = '0;
          end else begin
            phase_next          = PH_IDLE;
            high_surrogate_next = '0;
            res                 = err_res;
          end
        end
        PH_HEX1, PH_HEX2: begin
          if (!hex_d[4]) begin
            phase_next          = PH_IDLE;
            hex_accum_next      = '0;
            digit_count_next    = '0;
            high_surrogate_next = '0;
            res                 = err_res;
          end else if (digit_count != 2'd3) begin
            hex_accum_next   = acc_v;
            digit_count_next = digit_count + 2'd1;
          end else begin
            hex_accum_next   = '0;
            digit_count_next = '0;
            if (phase == PH_HEX1) begin
              if (acc_v >= LO_SUR_LO && acc_v <= LO_SUR_HI) begin
                phase_next = PH_IDLE;
                res        = err_res;
              end else if (acc_v >= HI_SUR_LO && acc_v <= HI_SUR_HI) begin
                phase_next          = PH_BS2;
                high_surrogate_next = acc_v[9:0];
              end else begin
                phase_next = PH_STR;
                res        = utf8_encode({5'b0, acc_v});
              end
            end else begin
              high_surrogate_next = '0;
              if (acc_v < LO_SUR_LO || acc_v > LO_SUR_HI) begin
                phase_next = PH_IDLE;
                res        = err_res;
              end else begin
                phase_next = PH_STR;
                res        = utf8_encode(supp_cp);
              end
            end
          end
        end
        default: begin
          phase_next          = PH_IDLE;
          hex_accum_next      = '0;
          digit_count_next    = '0;
          high_surrogate_next = '0;
          res                 = err_res;
        end
      endcase
    end
  end

  // State registers advance on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      hex_accum      <= '0;
      digit_count    <= '0;
      high_surrogate <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      hex_accum      <= hex_accum_next;
      digit_count    <= digit_count_next;
      high_surrogate <= high_surrogate_next;
    end
  end

  // Idle always means all escape state has been cleared.
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> hex_accum == '0 && digit_count == '0 && high_surrogate == '0)
    else $error("escape state not cleared in idle");

  // Done and error results are always single.
  a_single_ctl: assert property (@(posedge clk) disable iff (rst)
    res.kind != KIND_DATA |-> res.cnt == 3'd1)
    else $error("control result with more than one byte");

endmodule

[hdl/jsu_out_buf.sv]
// Result register: holds up to four result beats and sends them one per cycle while out_ready is high.
module jsu_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  jsu_pkg::res_t res,
  output logic          free,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic [1:0]    kind,
  output logic          last
);
  import jsu_pkg::*;

  logic            valid;
  logic [1:0]      idx;
  logic [1:0]      top;
  kind_t           kind_q;
  logic [3:0][7:0] bytes;
  logic [2:0]      cnt_m1;

  assign cnt_m1    = res.cnt - 3'd1;
  assign out_valid = valid;
  assign out_byte  = bytes[idx];
  assign kind      = kind_q;
  assign last      = (idx == top);
  assign free      = !valid || (out_ready && last);

  // Control: load a new set or step through the held one.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
      top   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= '0;
      top   <= cnt_m1[1:0];
    end else if (valid && out_ready) begin
      if (last) valid <= 1'b0;
      else      idx   <= idx + 2'd1;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      kind_q <= res.kind;
      bytes  <= res.bytes;
    end
  end

  // A new set never overwrites beats still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("result set loaded over pending beats");

  // The beat index stays within the held set.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> idx <= top)
    else $error("beat index past end of set");

endmodule

[hdl/json_string_unescaper.sv]
// JSON string unescaper top level: decoder plus result register.
// The first result beat of an accepted input beat is registered and shown in the next cycle.
// Throughput: one input byte per cycle while out_ready is high; an input that
// yields more than one result byte holds the input while the result register drains.
// Reset (rst, synchronous, active high) returns the decoder to idle with all
// escape state cleared and empties the result register.
module json_string_unescaper (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic       last
);
  import jsu_pkg::*;

  res_t res;
  logic free;
  logic accept;
  logic load;

  assign in_ready = free;
  assign accept   = in_valid && free;
  assign load     = accept && (res.cnt != 3'd0);

  jsu_decoder u_dec (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .res          (res)
  );

  jsu_out_buf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .res       (res),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .kind      (kind),
    .last      (last)
  );

endmodule
